// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`define ASSERT_DELAY(lbl, clk, rst_n, ante, lat, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
    else $error("assertion failed: delayed implication");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ASSERT_DELAY(lbl, clk, rst_n, ante, lat, cons)

`endif

`endif

// ===== src/pcu_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcu_pkg
// Widths, types and constants of the pairwise crosstalk unmixing pipeline.
// ---------------------------------------------------------------------------
package pcu_pkg;

  localparam int SAMPLE_BITS     = 18;
  localparam int SLOPE_FRAC_BITS = 14;
  localparam int SLOPE_BITS      = 16;
  localparam int LANES           = 4;
  localparam int PAIRS           = LANES / 2;
  localparam int SLOT_BITS       = $clog2(LANES);
  localparam int CFG_IDX_BITS    = 3;

  localparam int PROD_BITS  = SAMPLE_BITS + SLOPE_BITS;
  localparam int DPROD_BITS = 2 * SLOPE_BITS;
  localparam int SHIFT_BITS = SAMPLE_BITS + SLOPE_FRAC_BITS;
  localparam int NUM_BITS   = ((SHIFT_BITS > PROD_BITS) ? SHIFT_BITS : PROD_BITS) + 1;
  localparam int DEN_BITS   =
      ((2 * SLOPE_FRAC_BITS + 2 > DPROD_BITS) ? 2 * SLOPE_FRAC_BITS + 2 : DPROD_BITS) + 1;
  localparam int QBITS      = SAMPLE_BITS + 1;
  localparam int XBITS      = NUM_BITS + SLOPE_FRAC_BITS + 1;
  localparam int XH_BITS    = XBITS - QBITS;
  localparam int CMP_BITS   = (XH_BITS > DEN_BITS) ? XH_BITS : DEN_BITS;
  localparam int NUM_STAGES = QBITS + 5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SLOPE_BITS-1:0]  slope_t;

  localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [QBITS-1:0] HALF_MAG    = QBITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [QBITS-1:0] POS_MAX_MAG = HALF_MAG - QBITS'(1);

  localparam logic signed [DEN_BITS-1:0] ONE_SQ = DEN_BITS'(1) << (2 * SLOPE_FRAC_BITS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SLOPE_A_INTO_C = CFG_IDX_BITS'(0),
    CFG_SLOPE_C_INTO_A = CFG_IDX_BITS'(1),
    CFG_SLOPE_G_INTO_T = CFG_IDX_BITS'(2),
    CFG_SLOPE_T_INTO_G = CFG_IDX_BITS'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic [DEN_BITS-1:0] rem;
    logic [QBITS-1:0]    lo;
    logic [QBITS-1:0]    quo;
    logic                ovf;
    logic                neg;
  } div_lane_t;

  typedef struct packed {
    logic [DEN_BITS-1:0] dmag;
    logic                sing;
  } div_pair_t;

endpackage

// ===== src/pairwise_crosstalk_unmix.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// pairwise_crosstalk_unmix
// Removes dye crosstalk from A/C and G/T sample pairs by 2x2 matrix inversion.
// ---------------------------------------------------------------------------
// One sample transfer is taken in every cycle and each result appears on the
// out_ ports for one cycle, with out_valid high; the receiver cannot stall,
// so busy stays low. The fixed pipeline has one multiply stage, one numerator
// and determinant stage, one magnitude stage, one setup stage, 19 restoring
// division stages per channel (one quotient bit each) and one rounding and
// saturation stage.
module pairwise_crosstalk_unmix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pcu_pkg::sample_t     in_sample_a,
  input  pcu_pkg::sample_t     in_sample_c,
  input  pcu_pkg::sample_t     in_sample_g,
  input  pcu_pkg::sample_t     in_sample_t,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [pcu_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  pcu_pkg::slope_t      cfg_data,
  output logic                 out_valid,
  output pcu_pkg::sample_t     out_fixed_a,
  output pcu_pkg::sample_t     out_fixed_c,
  output pcu_pkg::sample_t     out_fixed_g,
  output pcu_pkg::sample_t     out_fixed_t,
  output logic                 out_pair_ac_singular,
  output logic                 out_pair_gt_singular,
  output logic                 out_clipped
);
  import pcu_pkg::*;

  slope_t                       slope_r [LANES];
  sample_t                      smp     [LANES];
  logic                         accept;
  logic [NUM_STAGES-1:0]        vld_r;

  sample_t                      own_r   [LANES];
  logic signed [PROD_BITS-1:0]  cross_r [LANES];
  logic signed [DPROD_BITS-1:0] dprod_r [PAIRS];

  logic signed [NUM_BITS-1:0]   num_r   [LANES];
  logic signed [DEN_BITS-1:0]   den_r   [PAIRS];

  logic [NUM_BITS-1:0]          mag_r   [LANES];
  logic                         neg_r   [LANES];
  logic [DEN_BITS-1:0]          dmag_r  [PAIRS];
  logic                         sing_r  [PAIRS];

  logic [XBITS-1:0]             xw      [LANES];
  div_lane_t                    dv_r    [QBITS+1][LANES];
  div_pair_t                    dp_r    [QBITS+1][PAIRS];

  logic [QBITS:0]               rnd_w   [LANES];
  logic [QBITS-1:0]             qmag_w  [LANES];
  logic [QBITS-1:0]             qneg_w  [LANES];
  sample_t                      res_nxt [LANES];
  logic [LANES-1:0]             clip_nxt;

  sample_t                      fixed_r [LANES];
  logic                         osing_r [PAIRS];
  logic                         clip_r;

  logic                         ac_out_zero;
  logic                         gt_out_zero;
  logic                         any_at_rail;

  function automatic div_lane_t div_step(div_lane_t cur, logic [DEN_BITS-1:0] dmag);
    logic [DEN_BITS:0] trial;
    div_lane_t         nxt;
    nxt     = cur;
    trial   = {cur.rem, cur.lo[QBITS-1]};
    nxt.lo  = cur.lo << 1;
    if (trial >= {1'b0, dmag}) begin
      nxt.rem = DEN_BITS'(trial - {1'b0, dmag});
      nxt.quo = {cur.quo[QBITS-2:0], 1'b1};
    end else begin
      nxt.rem = trial[DEN_BITS-1:0];
      nxt.quo = {cur.quo[QBITS-2:0], 1'b0};
    end
    return nxt;
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign smp[0] = in_sample_a;
  assign smp[1] = in_sample_c;
  assign smp[2] = in_sample_g;
  assign smp[3] = in_sample_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LANES; l++) begin
        slope_r[l] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLOPE_A_INTO_C, CFG_SLOPE_C_INTO_A,
        CFG_SLOPE_G_INTO_T, CFG_SLOPE_T_INTO_G: begin
          slope_r[cfg_index[SLOT_BITS-1:0]] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NUM_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      own_r[l]   <= smp[l];
      cross_r[l] <= PROD_BITS'(slope_r[l ^ 1]) * PROD_BITS'(smp[l ^ 1]);
    end
    for (int p = 0; p < PAIRS; p++) begin
      dprod_r[p] <= DPROD_BITS'(slope_r[2 * p]) * DPROD_BITS'(slope_r[2 * p + 1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      num_r[l] <= (NUM_BITS'(own_r[l]) <<< SLOPE_FRAC_BITS) - NUM_BITS'(cross_r[l]);
    end
    for (int p = 0; p < PAIRS; p++) begin
      den_r[p] <= ONE_SQ - DEN_BITS'(dprod_r[p]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      mag_r[l] <= num_r[l][NUM_BITS-1] ? NUM_BITS'(-num_r[l]) : NUM_BITS'(num_r[l]);
      neg_r[l] <= num_r[l][NUM_BITS-1] ^ den_r[l >> 1][DEN_BITS-1];
    end
    for (int p = 0; p < PAIRS; p++) begin
      dmag_r[p] <= den_r[p][DEN_BITS-1] ? DEN_BITS'(-den_r[p]) : DEN_BITS'(den_r[p]);
      sing_r[p] <= (den_r[p] == '0);
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xw[l] = {mag_r[l], {(SLOPE_FRAC_BITS+1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      dv_r[0][l].rem <= DEN_BITS'(xw[l][XBITS-1:QBITS]);
      dv_r[0][l].lo  <= xw[l][QBITS-1:0];
      dv_r[0][l].quo <= '0;
      dv_r[0][l].ovf <= CMP_BITS'(xw[l][XBITS-1:QBITS]) >= CMP_BITS'(dmag_r[l >> 1]);
      dv_r[0][l].neg <= neg_r[l];
    end
    for (int p = 0; p < PAIRS; p++) begin
      dp_r[0][p].dmag <= dmag_r[p];
      dp_r[0][p].sing <= sing_r[p];
    end
    for (int k = 0; k < QBITS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        dv_r[k+1][l] <= div_step(dv_r[k][l], dp_r[k][l >> 1].dmag);
      end
      for (int p = 0; p < PAIRS; p++) begin
        dp_r[k+1][p] <= dp_r[k][p];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rnd_w[l]  = {1'b0, dv_r[QBITS][l].quo} + (QBITS+1)'(1);
      qmag_w[l] = rnd_w[l][QBITS:1];
      qneg_w[l] = ~qmag_w[l] + QBITS'(1);
      if (dp_r[QBITS][l >> 1].sing) begin
        res_nxt[l]  = '0;
        clip_nxt[l] = 1'b0;
      end else if (dv_r[QBITS][l].neg) begin
        if (dv_r[QBITS][l].ovf || (qmag_w[l] > HALF_MAG)) begin
          res_nxt[l]  = SAT_MIN;
          clip_nxt[l] = 1'b1;
        end else begin
          res_nxt[l]  = qneg_w[l][SAMPLE_BITS-1:0];
          clip_nxt[l] = 1'b0;
        end
      end else begin
        if (dv_r[QBITS][l].ovf || (qmag_w[l] > POS_MAX_MAG)) begin
          res_nxt[l]  = SAT_MAX;
          clip_nxt[l] = 1'b1;
        end else begin
          res_nxt[l]  = qmag_w[l][SAMPLE_BITS-1:0];
          clip_nxt[l] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      fixed_r[l] <= res_nxt[l];
    end
    for (int p = 0; p < PAIRS; p++) begin
      osing_r[p] <= dp_r[QBITS][p].sing;
    end
    clip_r <= |clip_nxt;
  end

  assign out_valid            = vld_r[NUM_STAGES-1];
  assign out_fixed_a          = fixed_r[0];
  assign out_fixed_c          = fixed_r[1];
  assign out_fixed_g          = fixed_r[2];
  assign out_fixed_t          = fixed_r[3];
  assign out_pair_ac_singular = osing_r[0];
  assign out_pair_gt_singular = osing_r[1];
  assign out_clipped          = clip_r;

  assign ac_out_zero = (out_fixed_a == '0) && (out_fixed_c == '0);
  assign gt_out_zero = (out_fixed_g == '0) && (out_fixed_t == '0);
  assign any_at_rail = (out_fixed_a == SAT_MAX) || (out_fixed_a == SAT_MIN) ||
                       (out_fixed_c == SAT_MAX) || (out_fixed_c == SAT_MIN) ||
                       (out_fixed_g == SAT_MAX) || (out_fixed_g == SAT_MIN) ||
                       (out_fixed_t == SAT_MAX) || (out_fixed_t == SAT_MIN);

  `ASSERT_DELAY(a_fixed_latency, clk, rst_n, accept, NUM_STAGES, out_valid)
  `ASSERT_IMPLY(a_no_spurious_result, clk, rst_n, out_valid, $past(accept, NUM_STAGES))
  `ASSERT_IMPLY(a_ac_singular_zero, clk, rst_n, out_valid && out_pair_ac_singular, ac_out_zero)
  `ASSERT_IMPLY(a_gt_singular_zero, clk, rst_n, out_valid && out_pair_gt_singular, gt_out_zero)
  `ASSERT_IMPLY(a_clip_at_rail, clk, rst_n, out_valid && out_clipped, any_at_rail)

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for pairwise_crosstalk_unmix. A directed table covers
// identity slopes, rounding ties, saturation, singular and negative
// determinants and ignored register indexes. Random phases with fresh slopes
// follow. Each result is checked against the table or a bit-exact predictor.
// ---------------------------------------------------------------------------
module tb_top;
  import pcu_pkg::*;

  localparam int PIPE_LATENCY = 24;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 120;
  localparam longint unsigned QUO_LIMIT = 64'd1 << 44;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_UNUSED = CFG_IDX_BITS'(4);
  localparam slope_t SLOPE_MIN = 16'sh8000;
  localparam slope_t SLOPE_MAX = 16'sh7fff;
  localparam slope_t SLOPE_ONE = 16'sh4000;

  typedef struct {
    sample_t fa;
    sample_t fc;
    sample_t fg;
    sample_t ft;
    logic    sing_ac;
    logic    sing_gt;
    logic    clip;
  } unmix_result_t;

  typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] idx;
    slope_t                  value;
    sample_t                 a;
    sample_t                 c;
    sample_t                 g;
    sample_t                 t;
    unmix_result_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  sample_t in_sample_a, in_sample_c, in_sample_g, in_sample_t;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  slope_t cfg_data;
  logic out_valid;
  sample_t out_fixed_a, out_fixed_c, out_fixed_g, out_fixed_t;
  logic out_pair_ac_singular, out_pair_gt_singular, out_clipped;

  slope_t slope_ac, slope_ca, slope_gt, slope_tg;
  unmix_result_t pending_results[$];
  stim_row_t directed[$];
  int failures = 0;
  int n_samples = 0;
  int n_writes = 0;
  int n_checked = 0;
  int n_clipped = 0;
  int n_singular = 0;

  pairwise_crosstalk_unmix dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_sample_a          (in_sample_a),
    .in_sample_c          (in_sample_c),
    .in_sample_g          (in_sample_g),
    .in_sample_t          (in_sample_t),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_fixed_a          (out_fixed_a),
    .out_fixed_c          (out_fixed_c),
    .out_fixed_g          (out_fixed_g),
    .out_fixed_t          (out_fixed_t),
    .out_pair_ac_singular (out_pair_ac_singular),
    .out_pair_gt_singular (out_pair_gt_singular),
    .out_clipped          (out_clipped)
  );

  always #2 clk = ~clk;

  function automatic sample_t round_div_sat(input longint num, input longint den,
                                            inout logic clip);
    longint unsigned mag_n, mag_d, quo, rem, half;
    logic neg;
    mag_n = (num < 0) ? -num : num;
    mag_d = (den < 0) ? -den : den;
    quo = mag_n / mag_d;
    rem = mag_n % mag_d;
    half = 64'd1 << (SAMPLE_BITS - 1);
    neg = (num < 0) != (den < 0);
    for (int i = 0; i <= SLOPE_FRAC_BITS; i++) begin
      if (quo > QUO_LIMIT) begin
        quo = QUO_LIMIT;
      end
      quo = quo << 1;
      rem = rem << 1;
      if (rem >= mag_d) begin
        rem = rem - mag_d;
        quo = quo | 64'd1;
      end
    end
    quo = (quo + 64'd1) >> 1;
    if (neg) begin
      if (quo > half) begin
        clip = 1'b1;
        quo = half;
      end
      return sample_t'(-longint'(quo));
    end
    if (quo > half - 64'd1) begin
      clip = 1'b1;
      quo = half - 64'd1;
    end
    return sample_t'(quo);
  endfunction

  // The x output uses the slope of y into x, and the y output the slope of x into y.
  function automatic void solve_pair(input sample_t x, input sample_t y,
                                     input slope_t sx, input slope_t sy,
                                     output sample_t ox, output sample_t oy,
                                     output logic sing, inout logic clip);
    longint one, den;
    one = longint'(1) << SLOPE_FRAC_BITS;
    den = one * one - longint'(sx) * longint'(sy);
    sing = (den == 0);
    if (sing) begin
      ox = '0;
      oy = '0;
    end else begin
      ox = round_div_sat(longint'(x) * one - longint'(sx) * longint'(y), den, clip);
      oy = round_div_sat(longint'(y) * one - longint'(sy) * longint'(x), den, clip);
    end
  endfunction

  function automatic unmix_result_t predict_unmix(sample_t a, sample_t c,
                                                  sample_t g, sample_t t);
    unmix_result_t r;
    r.clip = 1'b0;
    solve_pair(a, c, slope_ca, slope_ac, r.fa, r.fc, r.sing_ac, r.clip);
    solve_pair(g, t, slope_tg, slope_gt, r.fg, r.ft, r.sing_gt, r.clip);
    return r;
  endfunction

  function automatic void singular_pair(output slope_t s0, output slope_t s1);
    case ($urandom_range(0, 3))
      0: begin
        s0 = SLOPE_ONE;
        s1 = SLOPE_ONE;
      end
      1: begin
        s0 = -SLOPE_ONE;
        s1 = -SLOPE_ONE;
      end
      2: begin
        s0 = SLOPE_MIN;
        s1 = -(SLOPE_ONE >>> 1);
      end
      default: begin
        s0 = -(SLOPE_ONE >>> 1);
        s1 = SLOPE_MIN;
      end
    endcase
  endfunction

  function automatic slope_t draw_slope();
    case ($urandom_range(0, 7))
      0: return SLOPE_MIN;
      1: return SLOPE_MAX;
      2: return '0;
      3, 4: return slope_t'($urandom);
      default: return slope_t'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 7))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return sample_t'(int'($urandom_range(0, 511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_BITS-1:0] idx, slope_t value);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t sample_row(sample_t a, sample_t c, sample_t g, sample_t t);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.a = a;
    r.c = c;
    r.g = g;
    r.t = t;
    return r;
  endfunction

  function automatic stim_row_t known_row(sample_t a, sample_t c, sample_t g, sample_t t,
                                          sample_t fa, sample_t fc, sample_t fg,
                                          sample_t ft, logic sing_ac, logic sing_gt,
                                          logic clip);
    stim_row_t r;
    r = sample_row(a, c, g, t);
    r.kind = ROW_KNOWN;
    r.want.fa = fa;
    r.want.fc = fc;
    r.want.fg = fg;
    r.want.ft = ft;
    r.want.sing_ac = sing_ac;
    r.want.sing_gt = sing_gt;
    r.want.clip = clip;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    directed = {directed, r};
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer,
  // with start still high so that a back-to-back item needs no toggle.
  task automatic feed_sample(sample_t a, sample_t c, sample_t g, sample_t t,
                             int max_gap, logic typed, unmix_result_t want);
    int gap;
    unmix_result_t exp_item;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_sample_a = a;
    in_sample_c = c;
    in_sample_g = g;
    in_sample_t = t;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (typed) begin
      exp_item = want;
    end else begin
      exp_item = predict_unmix(a, c, g, t);
    end
    pending_results = {pending_results, exp_item};
    n_samples++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_slope(logic [CFG_IDX_BITS-1:0] idx, slope_t value);
    repeat ($urandom_range(0, 3)) @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_SLOPE_A_INTO_C: slope_ac = value;
      CFG_SLOPE_C_INTO_A: slope_ca = value;
      CFG_SLOPE_G_INTO_T: slope_gt = value;
      CFG_SLOPE_T_INTO_G: slope_tg = value;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    unmix_result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result waiting");
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("fixed_a", exp_r.fa, out_fixed_a);
        check_field("fixed_c", exp_r.fc, out_fixed_c);
        check_field("fixed_g", exp_r.fg, out_fixed_g);
        check_field("fixed_t", exp_r.ft, out_fixed_t);
        check_field("pair_ac_singular", exp_r.sing_ac, out_pair_ac_singular);
        check_field("pair_gt_singular", exp_r.sing_gt, out_pair_gt_singular);
        check_field("clipped", exp_r.clip, out_clipped);
        n_checked++;
        if (exp_r.clip) n_clipped++;
        if (exp_r.sing_ac || exp_r.sing_gt) n_singular++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    slope_t ac_s, ca_s, gt_s, tg_s;
    int max_gap;
    unmix_result_t none;
    rst_n = 1'b0;
    start = 1'b0;
    in_sample_a = '0;
    in_sample_c = '0;
    in_sample_g = '0;
    in_sample_t = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    slope_ac = '0;
    slope_ca = '0;
    slope_gt = '0;
    slope_tg = '0;

    add_row(known_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0));
    add_row(known_row(SAT_MAX, SAT_MIN, -1, 1,
                      SAT_MAX, SAT_MIN, -1, 1, 1'b0, 1'b0, 1'b0));
    add_row(known_row(SAT_MIN, SAT_MAX, 12345, -54321,
                      SAT_MIN, SAT_MAX, 12345, -54321, 1'b0, 1'b0, 1'b0));
    // A half slope of C into A makes odd C values land on rounding ties.
    add_row(write_row(CFG_SLOPE_C_INTO_A, SLOPE_ONE >>> 1));
    add_row(known_row(0, 1, 7, -7, -1, 1, 7, -7, 1'b0, 1'b0, 1'b0));
    add_row(known_row(0, -3, 0, 0, 2, -3, 0, 0, 1'b0, 1'b0, 1'b0));
    add_row(write_row(CFG_SLOPE_C_INTO_A, SLOPE_MAX));
    add_row(known_row(SAT_MAX, SAT_MIN, 0, 0,
                      SAT_MAX, SAT_MIN, 0, 0, 1'b0, 1'b0, 1'b1));
    add_row(known_row(SAT_MIN, SAT_MAX, 0, 0,
                      SAT_MIN, SAT_MAX, 0, 0, 1'b0, 1'b0, 1'b1));
    add_row(write_row(CFG_SLOPE_A_INTO_C, SLOPE_ONE));
    add_row(write_row(CFG_SLOPE_C_INTO_A, SLOPE_ONE));
    add_row(known_row(1000, 2000, 3000, 4000,
                      0, 0, 3000, 4000, 1'b1, 1'b0, 1'b0));
    add_row(write_row(CFG_SLOPE_G_INTO_T, SLOPE_MIN));
    add_row(write_row(CFG_SLOPE_T_INTO_G, -(SLOPE_ONE >>> 1)));
    add_row(known_row(SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN,
                      0, 0, 0, 0, 1'b1, 1'b1, 1'b0));
    add_row(write_row(CFG_SLOPE_A_INTO_C, SLOPE_MIN));
    add_row(write_row(CFG_SLOPE_C_INTO_A, SLOPE_MAX));
    add_row(sample_row(SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN));
    add_row(write_row(CFG_SLOPE_G_INTO_T, SLOPE_MAX));
    add_row(write_row(CFG_SLOPE_T_INTO_G, SLOPE_MAX));
    add_row(sample_row(SAT_MAX, SAT_MIN, 100, -100));
    add_row(sample_row(5, -5, 99999, 12));
    for (int k = 0; k < 4; k++) begin
      add_row(write_row(CFG_FIRST_UNUSED + CFG_IDX_BITS'(k), SLOPE_ONE));
    end
    add_row(sample_row(-1, -1, -1, -1));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_WRITE: begin
          drain_results();
          write_slope(directed[i].idx, directed[i].value);
        end
        default: begin
          feed_sample(directed[i].a, directed[i].c, directed[i].g, directed[i].t, 3,
                      directed[i].kind == ROW_KNOWN, directed[i].want);
        end
      endcase
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain_results();
      ac_s = draw_slope();
      ca_s = draw_slope();
      gt_s = draw_slope();
      tg_s = draw_slope();
      case (phase)
        0: begin
          ac_s = SLOPE_MIN;
          ca_s = SLOPE_MIN;
          gt_s = SLOPE_MIN;
          tg_s = SLOPE_MIN;
        end
        1: begin
          ac_s = SLOPE_MAX;
          ca_s = SLOPE_MAX;
          gt_s = SLOPE_MAX;
          tg_s = SLOPE_MAX;
        end
        2: singular_pair(ac_s, ca_s);
        5: singular_pair(gt_s, tg_s);
        7: begin
          singular_pair(ac_s, ca_s);
          singular_pair(gt_s, tg_s);
        end
        default: ;
      endcase
      write_slope(CFG_SLOPE_A_INTO_C, ac_s);
      write_slope(CFG_SLOPE_C_INTO_A, ca_s);
      write_slope(CFG_SLOPE_G_INTO_T, gt_s);
      write_slope(CFG_SLOPE_T_INTO_G, tg_s);
      if (phase % 2 == 1) begin
        write_slope(CFG_FIRST_UNUSED + CFG_IDX_BITS'($urandom_range(0, 3)),
                    slope_t'($urandom));
      end
      max_gap = (phase % 3 == 1) ? 0 : 3;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase % 2 == 0 && n == PHASE_ITEMS / 2) drain_results();
        feed_sample(draw_sample(), draw_sample(), draw_sample(), draw_sample(),
                    max_gap, 1'b0, none);
      end
    end

    drain_results();
    repeat (2 * PIPE_LATENCY) @(negedge clk);
    $display("Checked %0d results from %0d sample transfers over %0d register writes.",
             n_checked, n_samples, n_writes);
    $display("%0d results were saturated and %0d had at least one singular pair.",
             n_clipped, n_singular);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/pcu_pkg.sv
src/pairwise_crosstalk_unmix.sv
sim/tb_top.sv
